>>> hw/rtl/iffc_pkg.sv
package iffc_pkg;

	typedef enum logic [3:0] {
		PH_FORM_TAG   = 4'd0,
		PH_FORM_LEN   = 4'd1,
		PH_TYPE_TAG   = 4'd2,
		PH_CHUNK_ID   = 4'd3,
		PH_CHUNK_LEN  = 4'd4,
		PH_BODY       = 4'd5,
		PH_PAD        = 4'd6,
		PH_FRAME_HDR  = 4'd7,
		PH_FRAME_VAL  = 4'd8,
		PH_STACK_SKIP = 4'd9,
		PH_TRAILING   = 4'd10
	} phase_t;

	localparam logic [2:0] FATAL_NONE     = 3'd0;
	localparam logic [2:0] FATAL_NO_FORM  = 3'd1;
	localparam logic [2:0] FATAL_PREMATURE = 3'd2;
	localparam logic [2:0] FATAL_NO_IFZS  = 3'd3;
	localparam logic [2:0] FATAL_SHORT    = 3'd4;
	localparam logic [2:0] FATAL_NO_ROOM  = 3'd5;
	localparam logic [2:0] FATAL_BAD_ID   = 3'd6;
	localparam logic [2:0] FATAL_OVERRUN  = 3'd7;

	localparam logic [1:0] VERDICT_VALID   = 2'd0;
	localparam logic [1:0] VERDICT_INVALID = 2'd1;
	localparam logic [1:0] VERDICT_FATAL   = 2'd2;

	localparam logic [3:0] KIND_UNKNOWN = 4'd0;
	localparam logic [3:0] KIND_IFHD    = 4'd1;
	localparam logic [3:0] KIND_CMEM    = 4'd2;
	localparam logic [3:0] KIND_UMEM    = 4'd3;
	localparam logic [3:0] KIND_STKS    = 4'd4;

	localparam logic [4:0] SEEN_HEADER = 5'h01;
	localparam logic [4:0] SEEN_MEMORY = 5'h02;
	localparam logic [4:0] SEEN_STACKS = 5'h04;
	localparam logic [4:0] SEEN_CMEM   = 5'h08;
	localparam logic [4:0] SEEN_UMEM   = 5'h10;

	localparam logic [7:0] ID_LOW  = 8'h20;
	localparam logic [7:0] ID_HIGH = 8'h7E;
	localparam logic [31:0] IFHD_MIN_LEN = 32'd13;

	typedef logic [31:0] id_table_t [10];
	localparam id_table_t ID_TABLE = '{
		32'h49466864, 32'h434D656D, 32'h554D656D, 32'h53746B73, 32'h496E7444,
		32'h414E4E4F, 32'h41555448, 32'h4E414D45, 32'h28632920, 32'h20202020
	};

	typedef logic [7:0] tag_t [4];
	localparam tag_t FORM_TAG = '{8'h46, 8'h4F, 8'h52, 8'h4D};
	localparam tag_t TYPE_TAG = '{8'h49, 8'h46, 8'h5A, 8'h53};

	typedef struct packed {
		logic        chunk_seen;
		logic [3:0]  chunk_kind;
		logic [31:0] chunk_length;
		logic [15:0] error_total;
		logic [15:0] warning_total;
		logic [2:0]  fatal_code;
		logic        finished;
		logic [1:0]  verdict;
		logic [2:0]  missing_mask;
	} result_t;

	function automatic logic [3:0] kind_of(input logic [31:0] id);
		logic [3:0] k;
		k = KIND_UNKNOWN;
		for (int i = 9; i >= 0; i--) begin
			if (ID_TABLE[i] == id) k = 4'(i + 1);
		end
		return k;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

>>> hw/rtl/iffc_parser.sv
module iffc_parser
	import iffc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output result_t     result
);

	phase_t      phase_q, ph;
	logic [2:0]  cnt_q, cnt;
	logic [31:0] form_q, form;
	logic [31:0] chunk_q, chunk;
	logic [31:0] tag_q, tag;
	logic        pad_q, pad;
	logic [4:0]  seen_q, seen;
	logic [15:0] err_q, err;
	logic [15:0] warn_q, warn;
	logic [31:0] stack_q, stack;
	logic [15:0] fhdr_q, fhdr;
	logic [16:0] fval_q, fval;
	logic        trail_q, trail;
	logic        stop_q, stop;
	logic [2:0]  fatal;
	result_t     res;

	logic [31:0] cklen, room, stack_dec;
	logic [3:0]  kind;
	logic [16:0] words;
	logic        bad_id;

	assign cklen = {chunk_q[23:0], data_byte};
	assign room = form_q - 32'd8;
	assign kind = kind_of(tag_q);
	assign stack_dec = stack_q - 32'd1;
	assign words = fval_q + {1'b0, fhdr_q[15:8], data_byte};
	// check the four ID bytes as they stand after this byte shifts in
	assign bad_id = (tag_q[23:16] < ID_LOW) || (tag_q[23:16] > ID_HIGH)
		|| (tag_q[15:8] < ID_LOW) || (tag_q[15:8] > ID_HIGH)
		|| (tag_q[7:0] < ID_LOW) || (tag_q[7:0] > ID_HIGH)
		|| (data_byte < ID_LOW) || (data_byte > ID_HIGH);

	always_comb begin
		logic [31:0] fl, sl;
		logic        pd, do_end, do_next, do_skip, do_bound;
		ph = phase_q; cnt = cnt_q; form = form_q; chunk = chunk_q; tag = tag_q;
		pad = pad_q; seen = seen_q; err = err_q; warn = warn_q; stack = stack_q;
		fhdr = fhdr_q; fval = fval_q; trail = trail_q; stop = stop_q;
		fatal = FATAL_NONE;
		res = '0;
		fl = form_q; sl = stack_q; pd = pad_q;
		do_end = 1'b0; do_next = 1'b0; do_skip = 1'b0; do_bound = 1'b0;
		if (!stop_q) begin
			if (end_of_stream) begin
				if (phase_q == PH_FORM_TAG) fatal = FATAL_NO_FORM;
				else if (phase_q == PH_TYPE_TAG) fatal = FATAL_NO_IFZS;
				else if (phase_q != PH_TRAILING) fatal = FATAL_PREMATURE;
				else begin
					if (trail_q) warn = sat_inc(warn_q);
					res.missing_mask = ~seen_q[2:0];
					res.verdict = (res.missing_mask != 3'd0 || err_q != 16'd0)
						? VERDICT_INVALID : VERDICT_VALID;
					res.finished = 1'b1;
					stop = 1'b1;
				end
			end else begin
				case (phase_q)
					PH_FORM_TAG: begin
						if (data_byte != FORM_TAG[cnt_q[1:0]]) fatal = FATAL_NO_FORM;
						else if (cnt_q == 3'd3) begin ph = PH_FORM_LEN; cnt = '0; end
						else cnt = cnt_q + 3'd1;
					end
					PH_FORM_LEN: begin
						form = {form_q[23:0], data_byte};
						if (cnt_q == 3'd3) begin ph = PH_TYPE_TAG; cnt = '0; end
						else cnt = cnt_q + 3'd1;
					end
					PH_TYPE_TAG: begin
						if (data_byte != TYPE_TAG[cnt_q[1:0]]) fatal = FATAL_NO_IFZS;
						else if (cnt_q == 3'd3) begin
							if (form_q < 32'd4) fatal = FATAL_SHORT;
							else begin
								fl = form_q - 32'd4;
								form = fl;
								if (fl[0]) err = sat_inc(err_q);
								do_bound = 1'b1;
							end
						end else cnt = cnt_q + 3'd1;
					end
					PH_CHUNK_ID: begin
						tag = {tag_q[23:0], data_byte};
						if (cnt_q == 3'd3) begin
							if (bad_id) fatal = FATAL_BAD_ID;
							else begin ph = PH_CHUNK_LEN; cnt = '0; chunk = '0; end
						end else cnt = cnt_q + 3'd1;
					end
					PH_CHUNK_LEN: begin
						chunk = cklen;
						if (cnt_q != 3'd3) cnt = cnt_q + 3'd1;
						else begin
							cnt = 3'd4;
							res.chunk_seen = 1'b1;
							res.chunk_kind = kind;
							res.chunk_length = cklen;
							if (cklen > room || (room - cklen) < {31'd0, cklen[0]})
								fatal = FATAL_OVERRUN;
							else begin
								fl = room - cklen - {31'd0, cklen[0]};
								form = fl;
								pd = cklen[0];
								pad = pd;
								if (kind == KIND_IFHD) begin
									if (seen_q[0]) warn = sat_inc(warn_q);
									else begin
										if (seen_q[2] || seen_q[1]) begin
											err = sat_inc(err_q);
											if (cklen < IFHD_MIN_LEN) err = sat_inc(sat_inc(err_q));
										end else if (cklen < IFHD_MIN_LEN) err = sat_inc(err_q);
										seen = seen_q | SEEN_HEADER;
									end
								end else if (kind == KIND_CMEM || kind == KIND_UMEM) begin
									if (seen_q[1]) warn = sat_inc(warn_q);
									else seen = seen_q | SEEN_MEMORY
										| ((kind == KIND_CMEM) ? SEEN_CMEM : SEEN_UMEM);
								end else if (kind == KIND_STKS) begin
									if (seen_q[2]) warn = sat_inc(warn_q);
								end
								if (kind == KIND_STKS && !seen_q[2]) begin
									seen = seen_q | SEEN_STACKS;
									chunk = '0;
									sl = cklen;
									stack = cklen;
									do_next = 1'b1;
								end else if (cklen == 32'd0) do_end = 1'b1;
								else ph = PH_BODY;
							end
						end
					end
					PH_BODY: begin
						chunk = chunk_q - 32'd1;
						if (chunk == 32'd0) do_end = 1'b1;
					end
					PH_PAD: begin
						pad = 1'b0; pd = 1'b0;
						do_bound = 1'b1;
					end
					PH_FRAME_HDR: begin
						sl = stack_dec;
						stack = sl;
						if (cnt_q == 3'd3) fval = {13'd0, data_byte[3:0]};
						else if (cnt_q == 3'd6) fhdr = {data_byte, 8'd0};
						if (cnt_q != 3'd7) cnt = cnt_q + 3'd1;
						else begin
							fhdr = {fhdr_q[15:8], data_byte};
							if ({15'd0, words} > {1'b0, sl[31:1]}) begin
								cnt = '0;
								do_skip = 1'b1;
							end else begin
								fval = words;
								cnt = '0;
								if (words == 17'd0) do_next = 1'b1;
								else ph = PH_FRAME_VAL;
							end
						end
					end
					PH_FRAME_VAL: begin
						sl = stack_dec;
						stack = sl;
						cnt = {2'b00, ~cnt_q[0]};
						if (cnt_q[0]) begin
							fval = fval_q - 17'd1;
							if (fval == 17'd0) do_next = 1'b1;
						end
					end
					PH_STACK_SKIP: begin
						sl = stack_dec;
						stack = sl;
						if (sl == 32'd0) begin err = sat_inc(err_q); do_end = 1'b1; end
					end
					default: trail = 1'b1;
				endcase
				// frame walk (next frame, skip the rest, or end the chunk), then pad and chunk-boundary check
				if (do_next) begin
					if (sl == 32'd0) do_end = 1'b1;
					else if (sl < 32'd8) do_skip = 1'b1;
					else begin
						ph = PH_FRAME_HDR; cnt = '0; fhdr = '0; fval = '0;
					end
				end
				if (do_skip) begin
					if (sl == 32'd0) begin err = sat_inc(err); do_end = 1'b1; end
					else ph = PH_STACK_SKIP;
				end
				if (do_end) begin
					if (pd) ph = PH_PAD;
					else do_bound = 1'b1;
				end
				if (do_bound) begin
					if (fl == 32'd0) ph = PH_TRAILING;
					else if (fl < 32'd8) fatal = FATAL_NO_ROOM;
					else begin ph = PH_CHUNK_ID; cnt = '0; end
				end
			end
			if (fatal != FATAL_NONE) begin
				res.fatal_code = fatal;
				res.finished = 1'b1;
				res.verdict = VERDICT_FATAL;
				res.missing_mask = '0;
				stop = 1'b1;
			end
		end
		res.error_total = err;
		res.warning_total = warn;
	end

	assign result = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FORM_TAG; cnt_q <= '0; form_q <= '0; chunk_q <= '0;
			tag_q <= '0; pad_q <= 1'b0; seen_q <= '0; err_q <= '0; warn_q <= '0;
			stack_q <= '0; fhdr_q <= '0; fval_q <= '0; trail_q <= 1'b0; stop_q <= 1'b0;
		end else if (step) begin
			phase_q <= ph; cnt_q <= cnt; form_q <= form; chunk_q <= chunk;
			tag_q <= tag; pad_q <= pad; seen_q <= seen; err_q <= err; warn_q <= warn;
			stack_q <= stack; fhdr_q <= fhdr; fval_q <= fval; trail_q <= trail;
			stop_q <= stop;
		end
	end

`ifndef NO_ASSERTIONS
	a_err_mono: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> err_q >= $past(err_q))
		else $error("error count went down");
	a_stop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |=> stop_q)
		else $error("stop flag cleared");
	a_fin_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.finished) |=> stop_q)
		else $error("verdict without stop");
`endif

endmodule

>>> hw/rtl/iff_save_file_checker.sv
// Byte-stream checker for IFZS save files. One byte per word on s_axis (tdata = data_byte,
// tuser = end_of_stream); every accepted word gives exactly one registered result word on
// m_axis. Throughput is one word per cycle: the parser state is updated on each accepted word
// and the result register with a one-entry skid buffer keeps s_axis_tready high unless two
// results wait. After a verdict or fatal code, later words yield only the counters.
module iff_save_file_checker
	import iffc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] end_of_stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] chunk_seen, [4:1] chunk_kind, [36:5] chunk_length, [52:37] error_total_out,
	// [68:53] warning_total_out, [71:69] fatal_code, [72] finished, [74:73] verdict,
	// [77:75] missing_mask, [79:78] zero
	output logic [79:0] m_axis_tdata
);

	result_t res;
	result_t out_q, skid_q;
	logic    out_v_q, skid_v_q, step;

	assign s_axis_tready = !skid_v_q;
	assign step = s_axis_tvalid && s_axis_tready;

	iffc_parser u_parser (
		.clk(clk), .arst_n(arst_n), .step(step),
		.data_byte(s_axis_tdata), .end_of_stream(s_axis_tuser), .result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || m_axis_tready) begin
				out_v_q <= skid_v_q || step;
				skid_v_q <= 1'b0;
			end else if (step) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			out_q <= skid_v_q ? skid_q : res;
		end
		if (step && out_v_q && !m_axis_tready) skid_q <= res;
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {2'b00, out_q.missing_mask, out_q.verdict, out_q.finished,
		out_q.fatal_code, out_q.warning_total, out_q.error_total, out_q.chunk_length,
		out_q.chunk_kind, out_q.chunk_seen};

`ifndef NO_ASSERTIONS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid full while output empty");
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !m_axis_tready) |=> skid_v_q && $stable(skid_q))
		else $error("skid word lost");
	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_v_q)
		else $error("accepted word produced no result");
`endif

endmodule

>>> tb/sv/tb_iff_save_file_checker.sv
module tb_iff_save_file_checker;
	import iffc_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       eos;
	} file_word_t;

	// Expected result and checker for one save-file byte stream.
	class save_file_scoreboard;
		result_t expected_q[$];
		int failures;
		int checked;
		int chunk_headers;
		logic [2:0] last_fatal;
		logic [1:0] last_verdict;

		phase_t      phase;
		int          byte_idx;
		logic [31:0] form_left;
		logic [31:0] chunk_left;
		logic [31:0] id_shift;
		logic        pad;
		logic [4:0]  seen;
		logic [15:0] err_cnt;
		logic [15:0] warn_cnt;
		logic [31:0] stack_left;
		logic [15:0] frame_words;
		logic [16:0] frame_vals;
		logic        trailing;
		logic        stopped;
		logic [2:0]  fatal_now;

		function new();
			phase = PH_FORM_TAG;
			byte_idx = 0;
			form_left = '0;
			chunk_left = '0;
			id_shift = '0;
			pad = 1'b0;
			seen = '0;
			err_cnt = '0;
			warn_cnt = '0;
			stack_left = '0;
			frame_words = '0;
			frame_vals = '0;
			trailing = 1'b0;
			stopped = 1'b0;
			fatal_now = FATAL_NONE;
			failures = 0;
			checked = 0;
			chunk_headers = 0;
			last_fatal = FATAL_NONE;
			last_verdict = VERDICT_VALID;
		endfunction

		function void bump_err();
			if (err_cnt != 16'hFFFF) err_cnt++;
		endfunction

		function void bump_warn();
			if (warn_cnt != 16'hFFFF) warn_cnt++;
		endfunction

		function void raise(logic [2:0] code);
			if (fatal_now == FATAL_NONE) fatal_now = code;
		endfunction

		function void at_boundary();
			if (form_left == 0) phase = PH_TRAILING;
			else if (form_left < 8) raise(FATAL_NO_ROOM);
			else begin
				phase = PH_CHUNK_ID;
				byte_idx = 0;
			end
		endfunction

		function void close_chunk();
			if (pad) phase = PH_PAD;
			else at_boundary();
		endfunction

		function void start_stack_skip();
			if (stack_left == 0) begin
				bump_err();
				close_chunk();
			end else begin
				phase = PH_STACK_SKIP;
			end
		endfunction

		function void advance_frame();
			if (stack_left == 0) close_chunk();
			else if (stack_left < 8) start_stack_skip();
			else begin
				phase = PH_FRAME_HDR;
				byte_idx = 0;
				frame_words = '0;
				frame_vals = '0;
			end
		endfunction

		function logic [3:0] chunk_type(logic [31:0] id);
			logic [3:0] k;
			k = KIND_UNKNOWN;
			for (int i = 0; i < 10; i++) begin
				if (k == KIND_UNKNOWN && ID_TABLE[i] == id) k = 4'(i + 1);
			end
			return k;
		endfunction

		function void parse_byte(logic [7:0] b, ref result_t r);
			logic [31:0] cklen, room;
			logic        odd, first_stack;
			logic [16:0] words;
			case (phase)
				PH_FORM_TAG: begin
					if (b != FORM_TAG[byte_idx]) raise(FATAL_NO_FORM);
					else if (++byte_idx >= 4) begin
						phase = PH_FORM_LEN;
						byte_idx = 0;
					end
				end
				PH_FORM_LEN: begin
					form_left = {form_left[23:0], b};
					if (++byte_idx >= 4) begin
						phase = PH_TYPE_TAG;
						byte_idx = 0;
					end
				end
				PH_TYPE_TAG: begin
					if (b != TYPE_TAG[byte_idx]) raise(FATAL_NO_IFZS);
					else if (++byte_idx >= 4) begin
						if (form_left < 4) raise(FATAL_SHORT);
						else begin
							form_left -= 4;
							if (form_left[0]) bump_err();
							at_boundary();
						end
					end
				end
				PH_CHUNK_ID: begin
					id_shift = {id_shift[23:0], b};
					if (++byte_idx >= 4) begin
						for (int i = 0; i < 32; i += 8) begin
							if (id_shift[i +: 8] < ID_LOW || id_shift[i +: 8] > ID_HIGH)
								raise(FATAL_BAD_ID);
						end
						if (fatal_now == FATAL_NONE) begin
							phase = PH_CHUNK_LEN;
							byte_idx = 0;
							chunk_left = '0;
						end
					end
				end
				PH_CHUNK_LEN: begin
					chunk_left = {chunk_left[23:0], b};
					if (++byte_idx >= 4) begin
						cklen = chunk_left;
						odd = cklen[0];
						r.chunk_seen = 1'b1;
						r.chunk_kind = chunk_type(id_shift);
						r.chunk_length = cklen;
						room = form_left - 8;
						first_stack = 1'b0;
						if (cklen > room || room - cklen < 32'(odd)) begin
							raise(FATAL_OVERRUN);
						end else begin
							form_left = room - cklen - 32'(odd);
							pad = odd;
							if (r.chunk_kind == KIND_IFHD) begin
								if (seen & SEEN_HEADER) bump_warn();
								else begin
									if (seen & (SEEN_STACKS | SEEN_MEMORY)) bump_err();
									seen |= SEEN_HEADER;
									if (cklen < IFHD_MIN_LEN) bump_err();
								end
							end else if (r.chunk_kind == KIND_CMEM || r.chunk_kind == KIND_UMEM) begin
								if (seen & SEEN_MEMORY) bump_warn();
								else seen |= SEEN_MEMORY |
									(r.chunk_kind == KIND_CMEM ? SEEN_CMEM : SEEN_UMEM);
							end else if (r.chunk_kind == KIND_STKS) begin
								if (seen & SEEN_STACKS) bump_warn();
								else begin
									seen |= SEEN_STACKS;
									chunk_left = '0;
									stack_left = cklen;
									first_stack = 1'b1;
									advance_frame();
								end
							end
							if (!first_stack) begin
								if (cklen == 0) close_chunk();
								else phase = PH_BODY;
							end
						end
					end
				end
				PH_BODY: begin
					chunk_left--;
					if (chunk_left == 0) close_chunk();
				end
				PH_PAD: begin
					pad = 1'b0;
					at_boundary();
				end
				PH_FRAME_HDR: begin
					stack_left--;
					if (byte_idx == 3) frame_vals = 17'(b[3:0]);
					else if (byte_idx == 6) frame_words = {b, 8'h00};
					else if (byte_idx == 7) frame_words = frame_words | 16'(b);
					if (++byte_idx >= 8) begin
						words = frame_vals + 17'(frame_words);
						if (32'(words) > stack_left / 2) start_stack_skip();
						else begin
							frame_vals = words;
							byte_idx = 0;
							if (words == 0) advance_frame();
							else phase = PH_FRAME_VAL;
						end
					end
				end
				PH_FRAME_VAL: begin
					stack_left--;
					byte_idx ^= 1;
					if (byte_idx == 0) begin
						frame_vals--;
						if (frame_vals == 0) advance_frame();
					end
				end
				PH_STACK_SKIP: begin
					stack_left--;
					if (stack_left == 0) begin
						bump_err();
						close_chunk();
					end
				end
				default: trailing = 1'b1;
			endcase
		endfunction

		function void note_word(logic [7:0] b, logic eos);
			result_t r;
			r = '0;
			fatal_now = FATAL_NONE;
			if (!stopped) begin
				if (!eos) parse_byte(b, r);
				else if (phase == PH_FORM_TAG) raise(FATAL_NO_FORM);
				else if (phase == PH_TYPE_TAG) raise(FATAL_NO_IFZS);
				else if (phase != PH_TRAILING) raise(FATAL_PREMATURE);
				else begin
					if (trailing) bump_warn();
					r.missing_mask = ~seen[2:0];
					r.verdict = (r.missing_mask != 0 || err_cnt != 0) ? VERDICT_INVALID
						: VERDICT_VALID;
					r.finished = 1'b1;
					stopped = 1'b1;
				end
				if (fatal_now != FATAL_NONE) begin
					r.fatal_code = fatal_now;
					r.finished = 1'b1;
					r.verdict = VERDICT_FATAL;
					r.missing_mask = '0;
					stopped = 1'b1;
				end
			end
			r.error_total = err_cnt;
			r.warning_total = warn_cnt;
			expected_q.push_back(r);
		endfunction

		function void compare(string name, longint unsigned e, longint unsigned a);
			if (e != a) begin
				$error("%s: expected %0d, got %0d", name, e, a);
				failures++;
			end
		endfunction

		function void check_word(logic [79:0] w);
			result_t e;
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected: %h", w);
				failures++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (e.chunk_seen) chunk_headers++;
			if (e.finished) begin
				last_fatal = e.fatal_code;
				last_verdict = e.verdict;
			end
			compare("chunk_seen", e.chunk_seen, w[0]);
			compare("chunk_kind", e.chunk_kind, w[4:1]);
			compare("chunk_length", e.chunk_length, w[36:5]);
			compare("error_total_out", e.error_total, w[52:37]);
			compare("warning_total_out", e.warning_total, w[68:53]);
			compare("fatal_code", e.fatal_code, w[71:69]);
			compare("finished", e.finished, w[72]);
			compare("verdict", e.verdict, w[74:73]);
			compare("missing_mask", e.missing_mask, w[77:75]);
			compare("pad bits", 0, w[79:78]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;

	save_file_scoreboard sb;
	file_word_t stream_q[$];
	int sent_count;
	bit quiet;
	bit long_hold_done;
	int end_mode;

	iff_save_file_checker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tdata, s_axis_tuser);
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
	end

	task automatic push_byte(logic [7:0] b);
		stream_q.push_back('{data: b, eos: 1'b0});
	endtask

	task automatic push_long(logic [31:0] v);
		for (int i = 3; i >= 0; i--) push_byte(v[i*8 +: 8]);
	endtask

	task automatic push_chunk(logic [31:0] id, int len);
		push_long(id);
		push_long(32'(len));
		for (int i = 0; i < len; i++) push_byte(8'($urandom));
		if (len % 2) push_byte(8'($urandom));
	endtask

	// First stacks chunk: a run of frames, sometimes with a broken tail.
	task automatic push_stacks();
		logic [7:0] body[$];
		int locals, words;
		repeat ($urandom_range(1, 4)) begin
			locals = $urandom_range(0, 3);
			words = $urandom_range(0, 3);
			repeat (3) body.push_back(8'($urandom));
			body.push_back({4'($urandom), 4'(locals)});
			repeat (2) body.push_back(8'($urandom));
			body.push_back(8'(words >> 8));
			body.push_back(8'(words));
			repeat (2 * (locals + words)) body.push_back(8'($urandom));
		end
		case ($urandom_range(0, 2))
			1: repeat ($urandom_range(1, 7)) body.push_back(8'($urandom));
			2: begin
				repeat (7) body.push_back(8'($urandom));
				body.push_back(8'hFF);
				repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
			end
			default: ;
		endcase
		push_long(ID_TABLE[KIND_STKS - 1]);
		push_long(32'(body.size()));
		foreach (body[i]) push_byte(body[i]);
		if (body.size() % 2) push_byte(8'($urandom));
	endtask

	function automatic logic [31:0] random_id();
		logic [31:0] id;
		for (int i = 0; i < 4; i++) id[i*8 +: 8] = 8'($urandom_range(ID_LOW, ID_HIGH));
		return id;
	endfunction

	task automatic build_file();
		int form_len;
		int pick;
		foreach (FORM_TAG[i]) push_byte(FORM_TAG[i]);
		push_long(0);
		foreach (TYPE_TAG[i]) push_byte(TYPE_TAG[i]);
		// memory first, then a short header: both an ordering and a length error
		push_chunk(ID_TABLE[KIND_CMEM - 1], 0);
		push_chunk(ID_TABLE[KIND_IFHD - 1], 5);
		push_chunk(ID_TABLE[KIND_UMEM - 1], 3);
		push_chunk(ID_TABLE[KIND_IFHD - 1], 13);
		push_stacks();
		while (stream_q.size() < 520) begin
			pick = $urandom_range(0, 10);
			if (pick == 10) push_chunk(random_id(), $urandom_range(0, 24));
			else push_chunk(ID_TABLE[pick], $urandom_range(0, 24));
		end
		form_len = stream_q.size() - 8;
		end_mode = $urandom_range(0, 7);
		case (end_mode)
			1: form_len += 1;
			2: form_len += 40;
			3: begin
				push_long({8'h1F, 24'h414243});
				push_long(0);
				form_len += 16;
			end
			4: begin
				push_long(ID_TABLE[4]);
				push_long(50);
				form_len += 18;
			end
			default: repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
		endcase
		for (int i = 0; i < 4; i++) stream_q[4 + i].data = 8'(form_len >> (8 * (3 - i)));
		stream_q.push_back('{data: 8'($urandom), eos: 1'b1});
		// words after the verdict only carry the counters
		repeat (3) stream_q.push_back('{data: 8'($urandom), eos: 1'($urandom)});
		stream_q.push_back('{data: 8'hA5, eos: 1'b0});
		stream_q.push_back('{data: 8'h5A, eos: 1'b1});
	endtask

	task automatic send_word(file_word_t w);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w.data;
		s_axis_tuser <= w.eos;
		do @(posedge clk); while (!s_axis_tready);
		sent_count++;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		sent_count = 0;
		quiet = 1'b0;
		long_hold_done = 1'b0;
		sb = new();
		build_file();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stream_q[i]) begin
			if (i > stream_q.size() - 80) quiet = 1'b1;
			send_word(stream_q[i]);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			$error("%0d results never arrived", sb.expected_q.size());
			sb.failures++;
		end
		$display("Sent %0d bytes of one save file (%0d chunk headers), checked %0d results.",
			sent_count, sb.chunk_headers, sb.checked);
		$display("Ending style %0d: verdict %0d, fatal code %0d.", end_mode, sb.last_verdict,
			sb.last_fatal);
		if (sb.failures == 0) begin
			$display("** iff_save_file_checker: PASSED **");
		end else begin
			$display("** iff_save_file_checker: FAILED **");
		end
		$finish;
	end

	// Receiver: random stalls, one long hold-off to back up the input side.
	initial begin
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && sent_count >= 100) begin
				long_hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (150) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	initial begin
		#2000000;
		$display("** iff_save_file_checker: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/iffc_pkg.sv
hw/rtl/iffc_parser.sv
hw/rtl/iff_save_file_checker.sv
tb/sv/tb_iff_save_file_checker.sv
